>>> rtl/spirv_module_structure_checker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shader module structure checker
// Shared concurrent assertion forms used by the checker's RTL modules.
// ----------------------------------------------------------------------------
`ifndef SPIRV_MODULE_STRUCTURE_CHECKER_DEFINES_SVH
`define SPIRV_MODULE_STRUCTURE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SMSC_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SMSC_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/smsc_pkg.sv
// ----------------------------------------------------------------------------
// smsc_pkg
// Constants, status codes and queue item types of the module structure checker.
// ----------------------------------------------------------------------------
package smsc_pkg;

  // Default module size limit in words
  localparam int unsigned MAX_WORDS_DEF = 65536;
  // Depth of the queues between front, back and result port
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Header words
  localparam logic [31:0] SPV_MAGIC = 32'h0723_0203;
  localparam logic [31:0] VER_MIN   = 32'h0001_0000;
  localparam logic [31:0] VER_MAX   = 32'h0001_0500;
  localparam int unsigned IDX_MAGIC   = 0;
  localparam int unsigned IDX_VERSION = 1;
  localparam int unsigned IDX_BOUND   = 3;
  localparam int unsigned IDX_SCHEMA  = 4;
  localparam int unsigned HDR_WORDS   = 5;

  // Instruction walk
  localparam logic [15:0] OP_MEMORY_MODEL = 16'd14;
  localparam logic [15:0] OP_ENTRY_POINT  = 16'd15;
  localparam logic [15:0] MEM_MODEL_LEN   = 16'd3;
  localparam logic [15:0] ENTRY_MIN_LEN   = 16'd5;
  localparam logic [31:0] EXEC_PIXEL      = 32'd4;
  localparam logic [31:0] EXEC_VERTEX     = 32'd0;
  localparam logic [31:0] NAME_MAIN       = 32'h6E69_616D;  // "main"
  localparam logic [2:0]  POS_EXEC        = 3'd1;
  localparam logic [2:0]  POS_NAME        = 3'd3;
  localparam logic [2:0]  POS_NAME_END    = 3'd4;
  localparam logic [2:0]  POS_MAX         = 3'd7;

  // Reported word count saturation
  localparam logic [16:0] SEEN_SAT = 17'h1_FFFF;

  // Status codes
  localparam logic [2:0] ST_VALID      = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_NO_ENTRY   = 3'd4;

  // Classified word, front to back
  typedef struct packed {
    logic        hdr_err;    // header word fails its check
    logic        walk;       // word belongs to the instruction stream
    logic        last;
    logic        size_bad;
    logic [16:0] seen;
    logic [15:0] count;      // word count field if this is an opcode word
    logic        is_mem;     // well-formed memory model opcode word
    logic        is_entry;   // entry point opcode word, long enough
    logic        exec_ok;    // matches expected execution model
    logic        name_ok;    // "main"
    logic        low_zero;   // low byte is NUL
  } word_item_t;

  // Verdict, back to result port
  typedef struct packed {
    logic [2:0]  status;
    logic        mem_seen;
    logic        entry_seen;
    logic [16:0] seen;
  } verdict_t;

endpackage

>>> rtl/smsc_fifo.sv
// ----------------------------------------------------------------------------
// smsc_fifo
// Small show-ahead queue used between the checker's stages.
// ----------------------------------------------------------------------------
`include "spirv_module_structure_checker_defines.svh"

module smsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SMSC_ASSERT_IMP(a_fifo_no_overfill, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "fifo overfilled")
  `SMSC_ASSERT_IMP(a_fifo_push_room, clk, rst, push, !full, "push into full fifo")
  `SMSC_ASSERT_NXT(a_fifo_pop_only, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1, "fifo level not decremented")

endmodule

>>> rtl/smsc_front.sv
// ----------------------------------------------------------------------------
// smsc_front
// Counts module words, checks the header and classifies each word for the walk.
// ----------------------------------------------------------------------------
module smsc_front #(
  parameter int unsigned MAX_WORDS = smsc_pkg::MAX_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [31:0]         module_word,
  input  logic                pixel_shader,
  input  logic                last_word,
  output smsc_pkg::word_item_t item
);
  import smsc_pkg::*;

  localparam int unsigned CAP   = MAX_WORDS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_WORDS + 2);
  localparam int unsigned EXT_W = (CNT_W > 17) ? CNT_W : 17;

  logic [CNT_W-1:0] word_counter;
  logic [CNT_W-1:0] word_counter_next;
  logic [EXT_W-1:0] cnt_ext;
  logic             stage_is_pixel;
  logic             stage_now;
  logic [15:0]      opcode;

  // Saturating word index
  assign word_counter_next = (word_counter < CNT_W'(CAP)) ? word_counter + 1'b1
                                                          : CNT_W'(CAP);
  assign cnt_ext   = EXT_W'(word_counter_next);
  assign stage_now = (word_counter == CNT_W'(IDX_MAGIC)) ? pixel_shader : stage_is_pixel;
  assign opcode    = module_word[15:0];

  // Classification
  always_comb begin
    item          = '0;
    item.last     = last_word;
    item.walk     = (word_counter >= CNT_W'(HDR_WORDS));
    item.size_bad = (word_counter_next < CNT_W'(HDR_WORDS)) ||
                    (word_counter_next > CNT_W'(MAX_WORDS));
    item.seen     = (cnt_ext > EXT_W'(SEEN_SAT)) ? SEEN_SAT : cnt_ext[16:0];
    item.count    = module_word[31:16];
    item.is_mem   = (opcode == OP_MEMORY_MODEL) && (module_word[31:16] == MEM_MODEL_LEN);
    item.is_entry = (opcode == OP_ENTRY_POINT) && (module_word[31:16] >= ENTRY_MIN_LEN);
    item.exec_ok  = (module_word == (stage_now ? EXEC_PIXEL : EXEC_VERTEX));
    item.name_ok  = (module_word == NAME_MAIN);
    item.low_zero = (module_word[7:0] == 8'h00);
    case (word_counter)
      CNT_W'(IDX_MAGIC):   item.hdr_err = (module_word != SPV_MAGIC);
      CNT_W'(IDX_VERSION): item.hdr_err = (module_word < VER_MIN) || (module_word > VER_MAX) ||
                                          (module_word[7:0] != 8'h00);
      CNT_W'(IDX_BOUND):   item.hdr_err = (module_word == 32'd0);
      CNT_W'(IDX_SCHEMA):  item.hdr_err = (module_word != 32'd0);
      default:             item.hdr_err = 1'b0;
    endcase
  end

  // Counter and stage flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter   <= '0;
      stage_is_pixel <= 1'b0;
    end else if (accept) begin
      word_counter   <= last_word ? '0 : word_counter_next;
      stage_is_pixel <= stage_now;
    end
  end

endmodule

>>> rtl/smsc_back.sv
// ----------------------------------------------------------------------------
// smsc_back
// Walks instructions by word count, holds the first error and forms the verdict.
// ----------------------------------------------------------------------------
`include "spirv_module_structure_checker_defines.svh"

module smsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  smsc_pkg::word_item_t item,
  input  logic                 item_valid,
  output logic                 item_pop,
  input  logic                 out_full,
  output logic                 verdict_push,
  output smsc_pkg::verdict_t   verdict
);
  import smsc_pkg::*;

  logic [15:0] instr_words_left;
  logic [15:0] instr_words_left_next;
  logic [2:0]  instr_position;
  logic [2:0]  instr_position_next;
  logic        entry_candidate;
  logic        entry_candidate_next;
  logic        memory_flag;
  logic        memory_flag_next;
  logic        entry_flag;
  logic        entry_flag_next;
  logic [2:0]  first_error;
  logic [2:0]  first_error_next;
  logic        flags_ok;

  assign item_pop     = item_valid && !out_full;
  assign verdict_push = item_pop && item.last;

  // Header errors and instruction walk
  always_comb begin
    instr_words_left_next = instr_words_left;
    instr_position_next   = instr_position;
    entry_candidate_next  = entry_candidate;
    memory_flag_next      = memory_flag;
    entry_flag_next       = entry_flag;
    first_error_next      = first_error;
    if (item.hdr_err) begin
      if (first_error == ST_VALID) begin
        first_error_next = ST_BAD_HEADER;
      end
    end else if (item.walk && (first_error == ST_VALID)) begin
      if (instr_words_left == 16'd0) begin
        // opcode word
        if (item.count == 16'd0) begin
          first_error_next = ST_INCOMPLETE;
        end else begin
          memory_flag_next      = memory_flag || item.is_mem;
          entry_candidate_next  = item.is_entry;
          instr_words_left_next = item.count - 16'd1;
          instr_position_next   = 3'd1;
        end
      end else begin
        // operand word
        if (entry_candidate) begin
          case (instr_position)
            POS_EXEC:     entry_candidate_next = item.exec_ok;
            POS_NAME:     entry_candidate_next = item.name_ok;
            POS_NAME_END: begin
              entry_flag_next      = entry_flag || item.low_zero;
              entry_candidate_next = 1'b0;
            end
            default:      entry_candidate_next = entry_candidate;
          endcase
        end
        instr_words_left_next = instr_words_left - 16'd1;
        if (instr_position < POS_MAX) begin
          instr_position_next = instr_position + 3'd1;
        end
      end
    end
  end

  // Verdict from the updated state
  always_comb begin
    if (item.size_bad) begin
      verdict.status = ST_BAD_SIZE;
    end else if (first_error_next != ST_VALID) begin
      verdict.status = first_error_next;
    end else if (instr_words_left_next != 16'd0) begin
      verdict.status = ST_INCOMPLETE;
    end else if (!memory_flag_next || !entry_flag_next) begin
      verdict.status = ST_NO_ENTRY;
    end else begin
      verdict.status = ST_VALID;
    end
    flags_ok           = (verdict.status == ST_VALID) || (verdict.status == ST_NO_ENTRY);
    verdict.mem_seen   = flags_ok && memory_flag_next;
    verdict.entry_seen = flags_ok && entry_flag_next;
    verdict.seen       = item.seen;
  end

  // Walk state; cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst || verdict_push) begin
      instr_words_left <= '0;
      instr_position   <= '0;
      entry_candidate  <= 1'b0;
      memory_flag      <= 1'b0;
      entry_flag       <= 1'b0;
      first_error      <= ST_VALID;
    end else if (item_pop) begin
      instr_words_left <= instr_words_left_next;
      instr_position   <= instr_position_next;
      entry_candidate  <= entry_candidate_next;
      memory_flag      <= memory_flag_next;
      entry_flag       <= entry_flag_next;
      first_error      <= first_error_next;
    end
  end

  `SMSC_ASSERT_IMP(a_back_no_drop, clk, rst, verdict_push, !out_full, "verdict pushed into full queue")
  `SMSC_ASSERT_NXT(a_back_cleared, clk, rst, verdict_push, (first_error == ST_VALID) && (instr_words_left == 16'd0) && !memory_flag && !entry_flag, "walk state not cleared after verdict")
  `SMSC_ASSERT_IMP(a_back_flags_masked, clk, rst, verdict_push && (verdict.status != ST_VALID) && (verdict.status != ST_NO_ENTRY), !verdict.mem_seen && !verdict.entry_seen, "flags reported with a structural error")

endmodule

>>> rtl/spirv_module_structure_checker.sv
// ----------------------------------------------------------------------------
// spirv_module_structure_checker
// Streams a shader module word by word, checks header and instruction framing,
// and reports one verdict per module on its last word.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          module_word, pixel_shader, last_word
//  result    pop / empty          status, memory_model_seen, entry_point_seen,
//                                 words_seen
//
//  One word is taken per cycle while full is low; a verdict reaches the result
//  ports once the last word's item has been registered in the word queue and
//  the back has written the verdict into the verdict queue; the front classifies
//  each word combinationally. The per-word rate is set by the back walk, which
//  updates its state once per word. Reset (rst, synchronous) empties both queues
//  and clears all state. A stalled result side fills the verdict queue, then the
//  word queue, and full rises; words already taken are never lost.
// ----------------------------------------------------------------------------
module spirv_module_structure_checker #(
  parameter int unsigned MAX_WORDS = smsc_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] module_word,
  input  logic        pixel_shader,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic        memory_model_seen,
  output logic        entry_point_seen,
  output logic [16:0] words_seen
);
  import smsc_pkg::*;

  localparam int unsigned ITEM_W = $bits(word_item_t);
  localparam int unsigned VERD_W = $bits(verdict_t);

  logic       accept;
  word_item_t front_item;
  word_item_t back_item;
  logic       mid_empty;
  logic       back_pop;
  logic       out_full;
  logic       verdict_push;
  verdict_t   verdict;
  verdict_t   head;

  assign accept = push && !full;

  // Front: count and classify
  smsc_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .module_word  (module_word),
    .pixel_shader (pixel_shader),
    .last_word    (last_word),
    .item         (front_item)
  );

  // Word queue between front and back
  smsc_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_word_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (back_pop),
    .rdata (back_item),
    .empty (mid_empty)
  );

  // Back: instruction walk and verdict
  smsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (back_item),
    .item_valid   (!mid_empty),
    .item_pop     (back_pop),
    .out_full     (out_full),
    .verdict_push (verdict_push),
    .verdict      (verdict)
  );

  // Verdict queue toward the result port
  smsc_fifo #(
    .WIDTH(VERD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_verdict_q (
    .clk   (clk),
    .rst   (rst),
    .push  (verdict_push),
    .wdata (verdict),
    .full  (out_full),
    .pop   (pop),
    .rdata (head),
    .empty (empty)
  );

  assign status            = head.status;
  assign memory_model_seen = head.mem_seen;
  assign entry_point_seen  = head.entry_seen;
  assign words_seen        = head.seen;

endmodule
